// ----- sv/snmp_pkg.sv -----
// ----------------------------------------------------------------------------
// snmp_pkg
// shared types and constants for the snmp get request parser
// ----------------------------------------------------------------------------
package snmp_pkg;

  localparam int OidDepth   = 16;
  localparam int OidIdxW    = $clog2(OidDepth);
  localparam int OidCntW    = $clog2(OidDepth + 1);
  localparam int MaxPayload = 2048;
  localparam int PosW       = $clog2(MaxPayload + 1);

  localparam logic [47:0] CommunityReset = 48'h737461747573;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_OUTER    = 4'd1,
    PH_VERSION  = 4'd2,
    PH_COMMUNITY= 4'd3,
    PH_PDU      = 4'd4,
    PH_REQID    = 4'd5,
    PH_ERRSTAT  = 4'd6,
    PH_ERRIDX   = 4'd7,
    PH_VARLIST  = 4'd8,
    PH_VARBIND  = 4'd9,
    PH_OID      = 4'd10,
    PH_DONE     = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_TAG  = 2'd0,
    ST_LENH = 2'd1,
    ST_LENX = 2'd2,
    ST_BODY = 2'd3
  } step_t;

  localparam logic [1:0] TargetNone    = 2'd0;
  localparam logic [1:0] TargetSensor  = 2'd1;
  localparam logic [1:0] TargetBattery = 2'd2;

  function automatic logic [7:0] expected_tag(input phase_t ph);
    logic [7:0] t;
    unique case (ph)
      PH_OUTER, PH_VARLIST, PH_VARBIND: t = 8'h30;
      PH_VERSION, PH_REQID, PH_ERRSTAT, PH_ERRIDX: t = 8'h02;
      PH_COMMUNITY: t = 8'h04;
      PH_PDU: t = 8'hA0;
      PH_OID: t = 8'h06;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/snmp_get_request_parser.sv -----
// ----------------------------------------------------------------------------
// snmp_get_request_parser
// byte-serial checker and decoder for snmp v1 get requests
// ----------------------------------------------------------------------------
// One payload byte is taken per word, one per clock with no gaps needed. Each
// byte's parse step is combinational and then registered; the word marked
// last_byte yields one result word, registered, in the next cycle. Input is
// held off only while a finished result is waiting and the output side stalls.
// ----------------------------------------------------------------------------
module snmp_get_request_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [10:0] payload_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        verdict,
  output logic [1:0]  target,
  output logic [13:0] section,
  output logic [7:0]  sensor_column,
  output logic [31:0] request_id,
  output logic [31:0] error_status,
  output logic [31:0] error_index,
  output logic [4:0]  oid_bytes
);

  localparam int PW = snmp_pkg::PosW;
  localparam int CW = snmp_pkg::OidCntW;

  logic [47:0] community;

  snmp_pkg::phase_t phase, phase_next;
  snmp_pkg::step_t  step, step_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] tot, tot_next;
  logic [15:0] len_acc, len_acc_next;
  logic [15:0] remain, remain_next;
  logic [31:0] int_acc, int_acc_next;
  logic [31:0] rid, rid_next, est, est_next, eix, eix_next;
  logic        cmatch, cmatch_next;
  logic [CW-1:0] ocnt, ocnt_next;
  logic        rej, rej_next;
  logic [7:0]  oid [snmp_pkg::OidDepth];
  logic        oid_we;
  logic [snmp_pkg::OidIdxW-1:0] oid_wa;
  // phase reached by this byte, before the last-byte idle override
  snmp_pkg::phase_t fphase;

  logic accept;
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // per-byte parse step
  always_comb begin
    logic [PW-1:0] p;
    logic [15:0]   rem;
    logic [15:0]   flen;
    logic          fin, endel;
    logic [2:0]    k;
    logic [7:0]    want;
    phase_next = phase; step_next = step; pos_next = pos; tot_next = tot;
    len_acc_next = len_acc; remain_next = remain; int_acc_next = int_acc;
    rid_next = rid; est_next = est; eix_next = eix; cmatch_next = cmatch;
    ocnt_next = ocnt; rej_next = rej; oid_we = 1'b0;
    oid_wa = ocnt[snmp_pkg::OidIdxW-1:0];
    fin = 1'b0; endel = 1'b0; flen = '0; rem = '0; k = '0; want = '0;
    if (first_byte) begin
      phase_next = snmp_pkg::PH_OUTER; step_next = snmp_pkg::ST_TAG;
      pos_next = '0; tot_next = PW'(payload_length);
      len_acc_next = '0; remain_next = '0; int_acc_next = '0;
      rid_next = '0; est_next = '0; eix_next = '0;
      cmatch_next = 1'b1; ocnt_next = '0; rej_next = 1'b0;
    end
    p = pos_next;
    if (pos_next < PW'(snmp_pkg::MaxPayload)) pos_next = pos_next + 1'b1;
    if (!rej_next && phase_next != snmp_pkg::PH_IDLE && phase_next != snmp_pkg::PH_DONE) begin
      if (p >= tot_next) begin
        rej_next = 1'b1;
      end else begin
        rem = 16'(tot_next - p - 1'b1);
        unique case (step_next)
          snmp_pkg::ST_TAG: begin
            if (data_byte != snmp_pkg::expected_tag(phase_next)) rej_next = 1'b1;
            else step_next = snmp_pkg::ST_LENH;
          end
          snmp_pkg::ST_LENH: begin
            if (!data_byte[7]) begin
              fin = 1'b1; flen = {8'd0, data_byte};
            end else if (data_byte == 8'h81 || data_byte == 8'h82) begin
              remain_next = {9'd0, data_byte[6:0]};
              len_acc_next = '0;
              step_next = snmp_pkg::ST_LENX;
            end else begin
              rej_next = 1'b1;
            end
          end
          snmp_pkg::ST_LENX: begin
            len_acc_next = {len_acc_next[7:0], data_byte};
            remain_next = remain_next - 1'b1;
            if (remain_next == '0) begin
              fin = 1'b1; flen = len_acc_next;
            end
          end
          default: begin
            if (phase_next == snmp_pkg::PH_COMMUNITY) begin
              k = 3'(len_acc_next - remain_next);
              if (cmatch_next && len_acc_next - remain_next < 16'd6) begin
                want = community[8*(5-k) +: 8];
                if (want != data_byte) cmatch_next = 1'b0;
              end
            end else if (phase_next == snmp_pkg::PH_OID) begin
              if (ocnt_next < CW'(snmp_pkg::OidDepth)) begin
                oid_we = 1'b1; ocnt_next = ocnt_next + 1'b1;
              end
            end else if (remain_next == len_acc_next) begin
              int_acc_next = {{24{data_byte[7]}}, data_byte};
            end else begin
              int_acc_next = {int_acc_next[23:0], data_byte};
            end
            remain_next = remain_next - 1'b1;
            if (remain_next == '0) endel = 1'b1;
          end
        endcase
        if (fin) begin
          len_acc_next = flen;
          if (phase_next == snmp_pkg::PH_OUTER || phase_next == snmp_pkg::PH_PDU ||
              phase_next == snmp_pkg::PH_VARLIST || phase_next == snmp_pkg::PH_VARBIND) begin
            if (flen != '0 && flen != rem) rej_next = 1'b1;
            else begin
              phase_next = snmp_pkg::phase_t'(phase_next + 1'b1);
              step_next = snmp_pkg::ST_TAG;
            end
          end else if (flen > rem) begin
            rej_next = 1'b1;
          end else begin
            remain_next = flen; int_acc_next = '0;
            if (phase_next == snmp_pkg::PH_COMMUNITY) cmatch_next = (flen == 16'd6);
            if (phase_next == snmp_pkg::PH_OID) ocnt_next = '0;
            if (flen == '0) endel = 1'b1;
            else step_next = snmp_pkg::ST_BODY;
          end
        end
        if (endel) begin
          unique case (phase_next)
            snmp_pkg::PH_VERSION:   if (int_acc_next != '0) rej_next = 1'b1;
            snmp_pkg::PH_COMMUNITY: if (!cmatch_next) rej_next = 1'b1;
            snmp_pkg::PH_REQID:     rid_next = int_acc_next;
            snmp_pkg::PH_ERRSTAT:   est_next = int_acc_next;
            snmp_pkg::PH_ERRIDX:    eix_next = int_acc_next;
            default: ;
          endcase
          phase_next = snmp_pkg::phase_t'(phase_next + 1'b1);
          step_next = snmp_pkg::ST_TAG;
        end
      end
    end
    fphase = phase_next;
    if (last_byte) begin
      phase_next = snmp_pkg::PH_IDLE; step_next = snmp_pkg::ST_TAG;
    end
  end

  // result from the state after this byte
  logic        ok;
  logic [1:0]  r_target;
  logic [13:0] r_section;
  logic [7:0]  r_column;
  logic [7:0]  o [10];
  always_comb begin
    for (int i = 0; i < 10; i++) o[i] = (oid_we && i == int'(oid_wa)) ? data_byte : oid[i];
  end
  always_comb begin
    ok = !rej_next && fphase == snmp_pkg::PH_DONE;
    r_target = snmp_pkg::TargetNone; r_section = '0; r_column = '0;
    if (ok && ocnt_next >= CW'(5) && o[0] == 8'h2B && o[1] == 8'd6 && o[2] == 8'd1
        && o[3] == 8'd2 && o[4] == 8'd1) begin
      if (ocnt_next < CW'(6)) ok = 1'b0;
      else begin
        r_section = {6'd0, o[5]};
        if (o[5][7]) begin
          if (ocnt_next < CW'(7)) ok = 1'b0;
          else r_section = {o[5][6:0], o[6][6:0]} | {6'd0, o[6][7], 7'd0};
        end
        if (ok && r_section == 14'd99) begin
          if (ocnt_next < CW'(10)) ok = 1'b0;
          else if (o[6] == 8'd1 && o[7] == 8'd1 && o[8] == 8'd1) begin
            r_target = snmp_pkg::TargetSensor; r_column = o[9];
          end
        end else if (ok && r_section == 14'd233) begin
          r_target = snmp_pkg::TargetBattery;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      community <= snmp_pkg::CommunityReset;
      phase <= snmp_pkg::PH_IDLE; step <= snmp_pkg::ST_TAG;
      pos <= '0; tot <= '0; len_acc <= '0; remain <= '0; int_acc <= '0;
      rid <= '0; est <= '0; eix <= '0; cmatch <= 1'b1; ocnt <= '0; rej <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) community <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        phase <= phase_next; step <= step_next; pos <= pos_next; tot <= tot_next;
        len_acc <= len_acc_next; remain <= remain_next; int_acc <= int_acc_next;
        rid <= rid_next; est <= est_next; eix <= eix_next; cmatch <= cmatch_next;
        ocnt <= ocnt_next; rej <= rej_next;
        if (last_byte) out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && oid_we) oid[oid_wa] <= data_byte;
    if (accept && last_byte) begin
      if (ok) begin
        verdict <= 1'b0; target <= r_target; section <= r_section;
        sensor_column <= r_column; request_id <= rid_next; error_status <= est_next;
        error_index <= eix_next; oid_bytes <= 5'(ocnt_next);
      end else begin
        verdict <= 1'b1; target <= '0; section <= '0; sensor_column <= '0;
        request_id <= '0; error_status <= '0; error_index <= '0; oid_bytes <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input held off with no result pending");
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
  assert property (@(posedge clk) disable iff (rst) ocnt <= CW'(snmp_pkg::OidDepth))
    else $error("oid count overflow");
  assert property (@(posedge clk) disable iff (rst) (accept && last_byte) |=> out_valid)
    else $error("last byte produced no result");

endmodule
